/* rtl/bmalloc_pkg.sv */
// Shared constants, command/status types and helpers for the bitmap allocator.
// Used by bmalloc_ctrl, bmalloc_dp and the top level; no dependencies.

package bmalloc_pkg;

  localparam int WORD_W    = 32;
  localparam int MAP_BITS  = 32768;
  localparam int MAP_WORDS = MAP_BITS / WORD_W;
  localparam int POS_W     = $clog2(WORD_W);
  localparam int WIDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(MAP_BITS);
  localparam int CNT_W     = 11;
  localparam int MEM_AW    = WIDX_W + 1;
  localparam int MEM_DEPTH = 2 * MAP_WORDS;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_SET   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_INODE_WORDS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_WORDS  = 1'b1;

  localparam logic [CNT_W-1:0] WORDS_RESET = CNT_W'(1024);

  typedef struct packed {
    logic clr_write;
    logic capture;
    logic rmw_read;
    logic rmw_write;
    logic scan_start;
    logic scan_step;
    logic finish;
    logic fin_found;
    logic fin_rerr;
  } bm_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_setclr;
    logic is_find;
    logic in_range;
    logic limit_zero;
    logic has_zero;
    logic scan_last;
  } bm_sts_t;

  // Position of the lowest zero bit; only meaningful when the word has one.
  function automatic logic [POS_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [POS_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) pos = POS_W'(i);
    end
    return pos;
  endfunction

endpackage

/* rtl/bmalloc_ctrl.sv */
// Controller state machine for the bitmap allocator.
// Depends on bmalloc_pkg; drives bmalloc_dp through bm_cmd_t and reads bm_sts_t.

module bmalloc_ctrl
  import bmalloc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  bm_sts_t sts,
  output bm_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ISSUE  = 3'd2;
  localparam logic [2:0] ST_MODIFY = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (sts.is_setclr && sts.in_range) begin
          cmd.rmw_read = 1'b1;
          state_nxt    = ST_MODIFY;
        end else if (sts.is_find && !sts.limit_zero) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          // Out-of-range set/clear, empty map find, or an unused opcode.
          cmd.finish   = 1'b1;
          cmd.fin_rerr = sts.is_setclr;
          state_nxt    = ST_IDLE;
        end
      end
      ST_MODIFY: begin
        cmd.rmw_write = 1'b1;
        cmd.finish    = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.has_zero) begin
          cmd.finish    = 1'b1;
          cmd.fin_found = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (sts.scan_last) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/bmalloc_dp.sv */
// Datapath of the bitmap allocator: word-count registers, bitmap memory,
// request capture, scan counters and result registers. Depends on bmalloc_pkg.

module bmalloc_dp
  import bmalloc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic                 in_map_select,
  input  logic [BIT_W-1:0]     in_bit_index,
  input  bm_cmd_t              cmd,
  output bm_sts_t              sts,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [BIT_W-1:0]     out_free_index,
  output logic                 out_range_error
);

  logic [CNT_W-1:0]  inode_words_r;
  logic [CNT_W-1:0]  data_words_r;
  logic [OP_W-1:0]   op_r;
  logic              map_r;
  logic [BIT_W-1:0]  bit_r;
  logic [MEM_AW-1:0] clr_addr_r;
  logic [WIDX_W-1:0] next_w_r;
  logic [WIDX_W-1:0] data_w_r;
  logic [WORD_W-1:0] rd_data_r;
  logic              valid_r;
  logic              found_r;
  logic [BIT_W-1:0]  free_index_r;
  logic              rerr_r;

  logic [WORD_W-1:0] mem [MEM_DEPTH];

  logic [CNT_W-1:0]  count_sel;
  logic [CNT_W-1:0]  limit;
  logic [MEM_AW-1:0] rmw_addr;
  logic [WORD_W-1:0] bit_mask;
  logic [WORD_W-1:0] modified;
  logic              mem_we;
  logic              mem_re;
  logic [MEM_AW-1:0] mem_waddr;
  logic [MEM_AW-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inode_words_r <= WORDS_RESET;
      data_words_r  <= WORDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INODE_WORDS: inode_words_r <= cfg_wdata;
        REG_DATA_WORDS:  data_words_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Counts above the map size saturate at the full map.
  assign count_sel = map_r ? data_words_r : inode_words_r;
  assign limit     = (count_sel > CNT_W'(MAP_WORDS)) ? CNT_W'(MAP_WORDS) : count_sel;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      map_r <= in_map_select;
      bit_r <= in_bit_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_write) begin
      clr_addr_r <= clr_addr_r + MEM_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      next_w_r <= WIDX_W'(1);
      data_w_r <= '0;
    end else if (cmd.scan_step) begin
      next_w_r <= next_w_r + WIDX_W'(1);
      data_w_r <= next_w_r;
    end
  end

  assign rmw_addr = {map_r, bit_r[BIT_W-1:POS_W]};
  assign bit_mask = WORD_W'(1) << bit_r[POS_W-1:0];
  assign modified = (op_r == OP_SET) ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);

  assign mem_we    = cmd.clr_write | cmd.rmw_write;
  assign mem_waddr = cmd.clr_write ? clr_addr_r : rmw_addr;
  assign mem_wdata = cmd.clr_write ? '0 : modified;
  assign mem_re    = cmd.rmw_read | cmd.scan_start | cmd.scan_step;
  assign mem_raddr = cmd.rmw_read   ? rmw_addr :
                     cmd.scan_start ? {map_r, WIDX_W'(0)} : {map_r, next_w_r};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= mem[mem_raddr];
  end

  always_comb begin
    sts            = '0;
    sts.clr_last   = (clr_addr_r == {MEM_AW{1'b1}});
    sts.is_setclr  = (op_r == OP_SET) || (op_r == OP_CLEAR);
    sts.is_find    = (op_r == OP_FIND);
    sts.in_range   = ({1'b0, bit_r[BIT_W-1:POS_W]} < limit);
    sts.limit_zero = (limit == '0);
    sts.has_zero   = (rd_data_r != {WORD_W{1'b1}});
    sts.scan_last  = ({1'b0, data_w_r} == (limit - CNT_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found_r      <= cmd.fin_found;
      free_index_r <= cmd.fin_found ? {data_w_r, lowest_zero(rd_data_r)} : '0;
      rerr_r       <= cmd.fin_rerr;
    end
  end

  assign out_valid       = valid_r;
  assign out_found       = found_r;
  assign out_free_index  = free_index_r;
  assign out_range_error = rerr_r;

endmodule

/* rtl/bitmap_allocator_find_first_free_unit.sv */
// Top level of the bitmap allocator: find-first-free over two allocation maps.
// Depends on bmalloc_pkg, bmalloc_ctrl and bmalloc_dp.
//
//   Channel  Ports                                   Handshake
//   input    in_opcode, in_map_select, in_bit_index  start && !busy
//   result   out_found, out_free_index,              out_valid, one cycle
//            out_range_error
//   config   cfg_index, cfg_wdata                    cfg_we, no wait
//
// Set and clear read the word in the issue state and write it in the modify state.
// Find reads the words of the map one per cycle, up to and including the word that
// holds the free bit or the last word in use. Requests that need no memory access
// (range error, empty map, unused opcode) finish in the issue state.
// After reset a clearing pass writes all 2048 words, one per cycle, with busy high.
// Results are shown for one cycle; the receiver cannot stall them.

module bitmap_allocator_find_first_free_unit
  import bmalloc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic                 in_map_select,
  input  logic [BIT_W-1:0]     in_bit_index,
  output logic                 out_valid,
  output logic                 out_found,
  output logic [BIT_W-1:0]     out_free_index,
  output logic                 out_range_error
);

  bm_cmd_t cmd;
  bm_sts_t sts;

  bmalloc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bmalloc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_opcode       (in_opcode),
    .in_map_select   (in_map_select),
    .in_bit_index    (in_bit_index),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_free_index  (out_free_index),
    .out_range_error (out_range_error)
  );

`ifndef SYNTHESIS
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an item was accepted");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_found_xor_rerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_range_error))
    else $error("found and range error both reported");

  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_free_index == '0))
    else $error("nonzero free index without a found bit");
`endif

endmodule
